// File: sv/assert_macros.svh
// assertion macros shared by the drive pid rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on an explicit clock, off while reset is asserted
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on the house clock and reset names
`define ASSERT_CK(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// File: sv/dpid_pkg.sv
// widths, register codes, reset values and shared types of the drive pid
// no dependencies; used by the interfaces and all modules
package dpid_pkg;

  localparam int PosW     = 24;  // target and encoder positions
  localparam int GainW    = 24;  // q8.16 gains and integral limit
  localparam int LimW     = 7;   // drive limits
  localparam int DrvW     = 8;   // drive outputs
  localparam int SideW    = PosW + 2;  // sum of three encoders
  localparam int AllW     = PosW + 3;  // sum of six encoders
  localparam int MagW     = 25;  // magnitude fed to the divide by three
  localparam int Div3W    = 26;
  localparam int Div3Sh   = 27;
  localparam int Div3ProdW = MagW + Div3W;
  localparam int QuoW     = Div3ProdW - Div3Sh;
  localparam int ErrW     = 25;
  localparam int DerW     = ErrW + 1;
  localparam int ProdW    = DerW + GainW + 1;
  localparam int AccW     = ProdW + 2;
  localparam int FracW    = 16;
  localparam int PwrW     = AccW - FracW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int NStg     = 8;   // pipeline registers, input to output

  // floor(x / 3) == (x * Div3Mult) >> Div3Sh for every x below 2**Div3Sh
  localparam logic [Div3W-1:0] Div3Mult = Div3W'(((1 << Div3Sh) + 1) / 3);

  localparam logic [GainW-1:0] GainPRst   = GainW'(1901);
  localparam logic [GainW-1:0] GainIRst   = GainW'(0);
  localparam logic [GainW-1:0] GainDRst   = GainW'(590);
  localparam logic [LimW-1:0]  MoveLimRst = LimW'(127);
  localparam logic [LimW-1:0]  TurnLimRst = LimW'(127);
  localparam logic [GainW-1:0] IntLimRst  = GainW'(5000);

  typedef enum logic [CfgIdxW-1:0] {
    RegGainP    = 3'd0,
    RegGainI    = 3'd1,
    RegGainD    = 3'd2,
    RegMoveLim  = 3'd3,
    RegTurnLim  = 3'd4,
    RegIntegLim = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic load;   // an item passes the integrator stage
    logic clear;  // drop the accumulated error first
    logic zero;   // stop request: keep the state
  } integ_ctl_t;

endpackage

// File: sv/dpid_if.sv
// valid/ready channels of the drive pid: control tick in, drive word out
// depends on dpid_pkg
interface dpid_in_if;
  import dpid_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] target;
  logic signed [PosW-1:0] left_front;
  logic signed [PosW-1:0] left_middle;
  logic signed [PosW-1:0] left_back;
  logic signed [PosW-1:0] right_front;
  logic signed [PosW-1:0] right_middle;
  logic signed [PosW-1:0] right_back;
  logic                   turning;
  logic                   clear_state;

  modport source (
    output valid, target, left_front, left_middle, left_back,
           right_front, right_middle, right_back, turning, clear_state,
    input  ready
  );
  modport sink (
    input  valid, target, left_front, left_middle, left_back,
           right_front, right_middle, right_back, turning, clear_state,
    output ready
  );
endinterface

interface dpid_out_if;
  import dpid_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [DrvW-1:0] left_drive;
  logic signed [DrvW-1:0] right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink (input valid, left_drive, right_drive, output ready);
endinterface

// File: sv/dpid_integ.sv
// integrator and derivative state of the drive pid: clamped error sum
// and last error; depends on dpid_pkg and assert_macros.svh
`include "assert_macros.svh"

module dpid_integ (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dpid_pkg::integ_ctl_t           ctl_i,
  input  logic signed [dpid_pkg::ErrW-1:0] err_i,
  input  logic [dpid_pkg::GainW-1:0]     lim_i,
  output logic signed [dpid_pkg::ErrW-1:0] sum_o,
  output logic signed [dpid_pkg::DerW-1:0] deriv_o
);
  import dpid_pkg::*;

  logic signed [ErrW-1:0] es_q, es_d, es_base;
  logic signed [ErrW-1:0] last_q, last_d;
  logic signed [DerW-1:0] raw, lim_s, clamped;

  assign es_base = ctl_i.clear ? '0 : es_q;
  assign raw     = DerW'(es_base) + DerW'(err_i);
  assign lim_s   = DerW'({1'b0, lim_i});

  always_comb begin
    if (raw > lim_s) begin
      clamped = lim_s;
    end else if (raw < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = raw;
    end
  end

  assign sum_o   = clamped[ErrW-1:0];
  assign deriv_o = DerW'(err_i) - DerW'(last_q);

  // a stop request leaves both values, except for an explicit clear
  assign es_d   = ctl_i.zero ? es_base : clamped[ErrW-1:0];
  assign last_d = ctl_i.zero ? last_q : err_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q   <= '0;
      last_q <= '0;
    end else if (ctl_i.load) begin
      es_q   <= es_d;
      last_q <= last_d;
    end
  end

  `ASSERT_CK(integ_in_limit_a,
    ctl_i.load && !ctl_i.zero |=> (DerW'(es_q) <= lim_s && DerW'(es_q) >= -lim_s),
    "error sum outside the integral limit after an update")
  `ASSERT_CK(integ_stop_keeps_last_a,
    ctl_i.load && ctl_i.zero |=> $stable(last_q),
    "last error changed on a stop request")

endmodule

// File: sv/drive_pid_controller_unit.sv
// Drive PID controller. One control tick is accepted per clock while ready
// is high; its drive word is presented on the output after it has passed
// eight registers (input register, encoder sums, divide-by-three multiply,
// error, integrator, gain multiplies, sum, saturate and output register).
// The only feedback loop, the error-sum and last-error update, closes inside
// one stage, so sustained throughput is one tick per cycle whenever the
// output side keeps taking words. Each stage holds while the one after it
// is full and stalled, so bubbles are squeezed out and ready stays high as
// long as any stage has room. The user must write registers (cfg_we_i,
// cfg_idx_i, cfg_wdata_i) only while no tick is in flight; the block does
// not enforce it. Unknown indexes are ignored, values cut to register width.
// depends on dpid_pkg, dpid_if, dpid_integ and assert_macros.svh
`include "assert_macros.svh"

module drive_pid_controller_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpid_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dpid_pkg::CfgDataW-1:0]   cfg_wdata_i,
  dpid_in_if.sink                         in_i,
  dpid_out_if.source                      out_o
);
  import dpid_pkg::*;

  // configuration registers
  logic [GainW-1:0] gain_p_q, gain_i_q, gain_d_q, int_lim_q;
  logic [LimW-1:0]  move_lim_q, turn_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q   <= GainPRst;
      gain_i_q   <= GainIRst;
      gain_d_q   <= GainDRst;
      move_lim_q <= MoveLimRst;
      turn_lim_q <= TurnLimRst;
      int_lim_q  <= IntLimRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegGainP:    gain_p_q   <= cfg_wdata_i[GainW-1:0];
        RegGainI:    gain_i_q   <= cfg_wdata_i[GainW-1:0];
        RegGainD:    gain_d_q   <= cfg_wdata_i[GainW-1:0];
        RegMoveLim:  move_lim_q <= cfg_wdata_i[LimW-1:0];
        RegTurnLim:  turn_lim_q <= cfg_wdata_i[LimW-1:0];
        RegIntegLim: int_lim_q  <= cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [NStg-1:0] stg_v_q;
  logic [NStg:0]   go;

  always_comb begin
    go[NStg] = out_o.ready;
    for (int k = NStg - 1; k >= 0; k--) begin
      go[k] = !stg_v_q[k] || go[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= '0;
    end else begin
      if (go[0]) begin
        stg_v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (go[k]) begin
          stg_v_q[k] <= stg_v_q[k-1];
        end
      end
    end
  end

  assign in_i.ready = go[0];

  // stage 0: input register
  logic signed [PosW-1:0] s0_tgt_q, s0_lf_q, s0_lm_q, s0_lb_q;
  logic signed [PosW-1:0] s0_rf_q, s0_rm_q, s0_rb_q;
  logic                   s0_turn_q, s0_clr_q;

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      s0_tgt_q  <= in_i.target;
      s0_lf_q   <= in_i.left_front;
      s0_lm_q   <= in_i.left_middle;
      s0_lb_q   <= in_i.left_back;
      s0_rf_q   <= in_i.right_front;
      s0_rm_q   <= in_i.right_middle;
      s0_rb_q   <= in_i.right_back;
      s0_turn_q <= in_i.turning;
      s0_clr_q  <= in_i.clear_state;
    end
  end

  // stage 1: encoder sums, sign and magnitude of the dividend
  logic signed [SideW-1:0] sum_l, sum_r, abs_r;
  logic signed [AllW-1:0]  sum_all, abs_all;
  logic [MagW-1:0]         mag_d;
  logic                    neg_d;

  assign sum_l   = SideW'(s0_lf_q) + SideW'(s0_lm_q) + SideW'(s0_lb_q);
  assign sum_r   = SideW'(s0_rf_q) + SideW'(s0_rm_q) + SideW'(s0_rb_q);
  assign sum_all = AllW'(sum_l) + AllW'(sum_r);
  assign abs_r   = sum_r[SideW-1] ? -sum_r : sum_r;
  assign abs_all = sum_all[AllW-1] ? -sum_all : sum_all;
  // straight mode: |s| / 6 == floor(|s| / 2) / 3
  assign mag_d   = s0_turn_q ? abs_r[MagW-1:0] : abs_all[MagW:1];
  assign neg_d   = s0_turn_q ? sum_r[SideW-1] : sum_all[AllW-1];

  logic [MagW-1:0]        s1_mag_q;
  logic                   s1_neg_q, s1_turn_q, s1_clr_q, s1_zero_q;
  logic signed [PosW-1:0] s1_tgt_q;

  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      s1_mag_q  <= mag_d;
      s1_neg_q  <= neg_d;
      s1_tgt_q  <= s0_tgt_q;
      s1_turn_q <= s0_turn_q;
      s1_clr_q  <= s0_clr_q;
      s1_zero_q <= (s0_tgt_q == '0);
    end
  end

  // stage 2: divide by three as a reciprocal multiply
  logic [Div3ProdW-1:0] div_prod;

  assign div_prod = Div3ProdW'(s1_mag_q) * Div3ProdW'(Div3Mult);

  logic [QuoW-1:0]        s2_quo_q;
  logic                   s2_neg_q, s2_turn_q, s2_clr_q, s2_zero_q;
  logic signed [PosW-1:0] s2_tgt_q;

  always_ff @(posedge clk_i) begin
    if (go[2]) begin
      s2_quo_q  <= div_prod[Div3ProdW-1:Div3Sh];
      s2_neg_q  <= s1_neg_q;
      s2_tgt_q  <= s1_tgt_q;
      s2_turn_q <= s1_turn_q;
      s2_clr_q  <= s1_clr_q;
      s2_zero_q <= s1_zero_q;
    end
  end

  // stage 3: error
  logic signed [ErrW-1:0] meas_mag, meas, err_d;

  assign meas_mag = ErrW'({1'b0, s2_quo_q});
  assign meas     = s2_neg_q ? -meas_mag : meas_mag;
  assign err_d    = ErrW'(s2_tgt_q) - meas;

  logic signed [ErrW-1:0] s3_err_q;
  logic                   s3_turn_q, s3_clr_q, s3_zero_q;

  always_ff @(posedge clk_i) begin
    if (go[3]) begin
      s3_err_q  <= err_d;
      s3_turn_q <= s2_turn_q;
      s3_clr_q  <= s2_clr_q;
      s3_zero_q <= s2_zero_q;
    end
  end

  // stage 4: integrator and derivative
  integ_ctl_t             integ_ctl;
  logic signed [ErrW-1:0] integ_sum;
  logic signed [DerW-1:0] integ_der;

  assign integ_ctl.load  = stg_v_q[3] && go[4];
  assign integ_ctl.clear = s3_clr_q;
  assign integ_ctl.zero  = s3_zero_q;

  dpid_integ u_integ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (integ_ctl),
    .err_i   (s3_err_q),
    .lim_i   (int_lim_q),
    .sum_o   (integ_sum),
    .deriv_o (integ_der)
  );

  logic signed [ErrW-1:0] s4_err_q, s4_sum_q;
  logic signed [DerW-1:0] s4_der_q;
  logic                   s4_turn_q, s4_zero_q;

  always_ff @(posedge clk_i) begin
    if (go[4]) begin
      s4_err_q  <= s3_err_q;
      s4_sum_q  <= integ_sum;
      s4_der_q  <= integ_der;
      s4_turn_q <= s3_turn_q;
      s4_zero_q <= s3_zero_q;
    end
  end

  // stage 5: gain products in q.16
  logic signed [ProdW-1:0] prod_p, prod_i, prod_d;

  assign prod_p = ProdW'(s4_err_q) * ProdW'({1'b0, gain_p_q});
  assign prod_i = ProdW'(s4_sum_q) * ProdW'({1'b0, gain_i_q});
  assign prod_d = ProdW'(s4_der_q) * ProdW'({1'b0, gain_d_q});

  logic signed [ProdW-1:0] s5_pp_q, s5_pi_q, s5_pd_q;
  logic                    s5_turn_q, s5_zero_q;

  always_ff @(posedge clk_i) begin
    if (go[5]) begin
      s5_pp_q   <= prod_p;
      s5_pi_q   <= prod_i;
      s5_pd_q   <= prod_d;
      s5_turn_q <= s4_turn_q;
      s5_zero_q <= s4_zero_q;
    end
  end

  // stage 6: accumulate
  logic signed [AccW-1:0] acc_d;

  assign acc_d = AccW'(s5_pp_q) + AccW'(s5_pi_q) + AccW'(s5_pd_q);

  logic signed [AccW-1:0] s6_acc_q;
  logic                   s6_turn_q, s6_zero_q;

  always_ff @(posedge clk_i) begin
    if (go[6]) begin
      s6_acc_q  <= acc_d;
      s6_turn_q <= s5_turn_q;
      s6_zero_q <= s5_zero_q;
    end
  end

  // stage 7: drop the fraction toward zero, saturate, map to both sides
  logic signed [AccW-1:0] acc_rnd;
  logic signed [PwrW-1:0] pwr, plim;
  logic signed [DrvW-1:0] pclamp, left_d, right_d;

  assign acc_rnd = s6_acc_q + (s6_acc_q[AccW-1] ? AccW'((1 << FracW) - 1) : '0);
  assign pwr     = acc_rnd[AccW-1:FracW];
  assign plim    = PwrW'({1'b0, s6_turn_q ? turn_lim_q : move_lim_q});

  always_comb begin
    if (s6_zero_q) begin
      pclamp = '0;
    end else if (pwr > plim) begin
      pclamp = plim[DrvW-1:0];
    end else if (pwr < -plim) begin
      pclamp = -plim[DrvW-1:0];
    end else begin
      pclamp = pwr[DrvW-1:0];
    end
  end

  assign left_d  = s6_turn_q ? pclamp : -pclamp;
  assign right_d = -pclamp;

  logic signed [DrvW-1:0] s7_left_q, s7_right_q;
  logic                   s7_turn_q;

  always_ff @(posedge clk_i) begin
    if (go[7]) begin
      s7_left_q  <= left_d;
      s7_right_q <= right_d;
      s7_turn_q  <= s6_turn_q;
    end
  end

  assign out_o.valid       = stg_v_q[NStg-1];
  assign out_o.left_drive  = s7_left_q;
  assign out_o.right_drive = s7_right_q;

  logic signed [DrvW-1:0] out_lim;

  assign out_lim = DrvW'({1'b0, s7_turn_q ? turn_lim_q : move_lim_q});

  `ASSERT_CK(drive_within_limit_a,
    stg_v_q[NStg-1] |-> (s7_left_q <= out_lim && s7_left_q >= -out_lim),
    "drive word beyond the selected limit")
  `ASSERT_CK(drive_mirror_a,
    stg_v_q[NStg-1] |-> (s7_turn_q ? (s7_left_q == -s7_right_q) : (s7_left_q == s7_right_q)),
    "left and right drives do not match the mode")
  `ASSERT_CK(integ_feeds_stage_a,
    integ_ctl.load |=> stg_v_q[4],
    "integrator updated without a word entering the next stage")

endmodule

// File: verif/tb_drive_pid_controller_unit.sv
`timescale 1ns / 1ps
// self-checking bench for drive_pid_controller_unit: random control ticks vs a
// behavioral pid predictor under several register settings
// depends on dpid_pkg, dpid_if and the unit itself
module tb_drive_pid_controller_unit;
  import dpid_pkg::*;

  localparam int StallLimit = 5000;
  localparam int DrainWait  = 16;
  localparam int PhaseTicks = 250;
  localparam int ChunkTicks = 50;

  localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};
  localparam logic [GainW-1:0]       GainMax = '1;
  localparam logic [GainW-1:0]       GainTyp = GainW'(4 * 65536);
  localparam logic [LimW-1:0]        LimMax  = '1;
  // unmapped register indexes, writes must be dropped
  localparam logic [CfgIdxW-1:0]     RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0]     RegSpareHi = 3'd7;

  typedef struct {
    logic signed [PosW-1:0] target;
    logic signed [PosW-1:0] left_front;
    logic signed [PosW-1:0] left_middle;
    logic signed [PosW-1:0] left_back;
    logic signed [PosW-1:0] right_front;
    logic signed [PosW-1:0] right_middle;
    logic signed [PosW-1:0] right_back;
    logic                   turning;
    logic                   clear_state;
  } tick_t;

  typedef struct {
    logic signed [DrvW-1:0] left;
    logic signed [DrvW-1:0] right;
  } drive_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  dpid_in_if  in_ch ();
  dpid_out_if out_ch ();

  drive_pid_controller_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // predictor copy of registers and loop state
  logic [GainW-1:0]       kp = GainPRst;
  logic [GainW-1:0]       ki = GainIRst;
  logic [GainW-1:0]       kd = GainDRst;
  logic [LimW-1:0]        lim_move = MoveLimRst;
  logic [LimW-1:0]        lim_turn = TurnLimRst;
  logic [GainW-1:0]       lim_integ = IntLimRst;
  logic signed [ErrW-1:0] integ_sum = '0;
  logic signed [ErrW-1:0] prev_err = '0;

  tick_t  ticks_pending[$];
  drive_t drive_expected[$];

  int n_offered = 0;
  int n_ticks_in = 0;
  int n_turn = 0;
  int n_stop = 0;
  int n_clear = 0;
  int n_sat = 0;
  int n_words = 0;
  int n_bad = 0;
  int n_backpressure = 0;
  int n_settings = 0;
  int idle_cycles = 0;

  int   tx_gap = 0;
  bit   tx_steady = 0;
  int   rx_stall = 0;
  int   rx_hold = 0;
  bit   rx_hold_req = 0;
  bit   rx_steady = 0;

  always #1ns clk_i = ~clk_i;

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // expected word for one tick; non-stop ticks advance integrator and last error
  function automatic drive_t drive_for_tick(tick_t t);
    longint side_l, side_r, meas, err, integ, der, acc, pwr, lim;
    drive_t d;
    d.left = '0;
    d.right = '0;
    if (t.clear_state) integ_sum = '0;
    if (t.target == '0) return d;
    side_l = longint'(t.left_front) + longint'(t.left_middle) + longint'(t.left_back);
    side_r = longint'(t.right_front) + longint'(t.right_middle) + longint'(t.right_back);
    // integer division truncates toward zero
    meas = t.turning ? side_r / 3 : (side_l + side_r) / 6;
    err = longint'(t.target) - meas;
    integ = clamp_sym(longint'(integ_sum) + err, longint'(lim_integ));
    integ_sum = ErrW'(integ);
    der = err - longint'(prev_err);
    prev_err = ErrW'(err);
    acc = err * longint'(kp) + integ * longint'(ki) + der * longint'(kd);
    pwr = acc / (longint'(1) << FracW);
    lim = t.turning ? longint'(lim_turn) : longint'(lim_move);
    if (pwr > lim || pwr < -lim) n_sat++;
    pwr = clamp_sym(pwr, lim);
    d.left = DrvW'(t.turning ? pwr : -pwr);
    d.right = DrvW'(-pwr);
    return d;
  endfunction

  function automatic tick_t mk_tick(logic signed [PosW-1:0] tgt,
                                    logic signed [PosW-1:0] lf, logic signed [PosW-1:0] lm,
                                    logic signed [PosW-1:0] lb, logic signed [PosW-1:0] rf,
                                    logic signed [PosW-1:0] rm, logic signed [PosW-1:0] rb,
                                    logic turn, logic clr);
    tick_t t;
    t.target = tgt;
    t.left_front = lf;
    t.left_middle = lm;
    t.left_back = lb;
    t.right_front = rf;
    t.right_middle = rm;
    t.right_back = rb;
    t.turning = turn;
    t.clear_state = clr;
    return t;
  endfunction

  function automatic logic signed [PosW-1:0] pick_corner();
    case ($urandom_range(0, 4))
      0: return PosMax;
      1: return PosMin;
      2: return '0;
      3: return '1;
      default: return PosW'(1);
    endcase
  endfunction

  // mostly plausible ticks: wheels near one base, target a few turns away
  function automatic tick_t random_tick();
    int    base, r;
    tick_t t;
    r = $urandom_range(0, 99);
    t.turning = ($urandom_range(0, 2) == 0);
    t.clear_state = ($urandom_range(0, 19) == 0);
    if (r < 70) begin
      base = int'($urandom_range(0, 2097152)) - 1048576;
      t.left_front = PosW'(base + int'($urandom_range(0, 400)) - 200);
      t.left_middle = PosW'(base + int'($urandom_range(0, 400)) - 200);
      t.left_back = PosW'(base + int'($urandom_range(0, 400)) - 200);
      t.right_front = PosW'(base + int'($urandom_range(0, 400)) - 200);
      t.right_middle = PosW'(base + int'($urandom_range(0, 400)) - 200);
      t.right_back = PosW'(base + int'($urandom_range(0, 400)) - 200);
      if ($urandom_range(0, 19) == 0) t.target = '0;
      else t.target = PosW'(base + int'($urandom_range(0, 10000)) - 5000);
    end else if (r < 90) begin
      t.target = PosW'($urandom());
      t.left_front = PosW'($urandom());
      t.left_middle = PosW'($urandom());
      t.left_back = PosW'($urandom());
      t.right_front = PosW'($urandom());
      t.right_middle = PosW'($urandom());
      t.right_back = PosW'($urandom());
    end else begin
      t.target = pick_corner();
      t.left_front = pick_corner();
      t.left_middle = pick_corner();
      t.left_back = pick_corner();
      t.right_front = pick_corner();
      t.right_middle = pick_corner();
      t.right_back = pick_corner();
    end
    return t;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_reg_value(logic [CfgDataW-1:0] hi,
                                                         logic [CfgDataW-1:0] typ);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return hi;
      2: return CfgDataW'($urandom_range(0, hi));
      default: return CfgDataW'($urandom_range(0, typ));
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      RegGainP:    kp = val[GainW-1:0];
      RegGainI:    ki = val[GainW-1:0];
      RegGainD:    kd = val[GainW-1:0];
      RegMoveLim:  lim_move = val[LimW-1:0];
      RegTurnLim:  lim_turn = val[LimW-1:0];
      RegIntegLim: lim_integ = val[GainW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic [CfgDataW-1:0] gp, input logic [CfgDataW-1:0] gi,
                                input logic [CfgDataW-1:0] gd, input logic [CfgDataW-1:0] ml,
                                input logic [CfgDataW-1:0] tl, input logic [CfgDataW-1:0] il);
    write_reg(RegGainP, gp);
    write_reg(RegGainI, gi);
    write_reg(RegGainD, gd);
    write_reg(RegMoveLim, ml);
    write_reg(RegTurnLim, tl);
    write_reg(RegIntegLim, il);
    n_settings++;
  endtask

  task automatic wait_drained();
    while (ticks_pending.size() != 0 || n_ticks_in != n_offered ||
           drive_expected.size() != 0)
      @(posedge clk_i);
  endtask

  // tick driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) tx_steady = ~tx_steady;
      if (in_ch.valid && n_ticks_in != n_offered) begin
        // word still waiting for ready
      end else if (tx_gap > 0) begin
        in_ch.valid <= 1'b0;
        tx_gap--;
      end else if (ticks_pending.size() != 0) begin
        tick_t t;
        t = ticks_pending.pop_front();
        in_ch.target <= t.target;
        in_ch.left_front <= t.left_front;
        in_ch.left_middle <= t.left_middle;
        in_ch.left_back <= t.left_back;
        in_ch.right_front <= t.right_front;
        in_ch.right_middle <= t.right_middle;
        in_ch.right_back <= t.right_back;
        in_ch.turning <= t.turning;
        in_ch.clear_state <= t.clear_state;
        in_ch.valid <= 1'b1;
        n_offered++;
        // keep pushing while the output side is held off
        tx_gap = (tx_steady || rx_hold > 0) ? 0 : pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // drive word receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold = 120;
      end
      if ($urandom_range(0, 127) == 0) rx_steady = ~rx_steady;
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        out_ch.ready <= 1'b0;
        rx_stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      bit     took_in, took_out;
      tick_t  t;
      drive_t exp_d;
      took_in = in_ch.valid && in_ch.ready;
      took_out = out_ch.valid && out_ch.ready;
      if (in_ch.valid && !in_ch.ready) n_backpressure++;
      if (took_in) begin
        t = mk_tick(in_ch.target, in_ch.left_front, in_ch.left_middle, in_ch.left_back,
                    in_ch.right_front, in_ch.right_middle, in_ch.right_back,
                    in_ch.turning, in_ch.clear_state);
        drive_expected.push_back(drive_for_tick(t));
        n_ticks_in++;
        if (t.turning) n_turn++;
        if (t.target == '0) n_stop++;
        if (t.clear_state) n_clear++;
      end
      if (took_out) begin
        n_words++;
        if (drive_expected.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("drive word with no tick pending: left %0d right %0d",
                     out_ch.left_drive, out_ch.right_drive);
        end else begin
          exp_d = drive_expected.pop_front();
          if (exp_d.left !== out_ch.left_drive || exp_d.right !== out_ch.right_drive) begin
            n_bad++;
            if (n_bad <= 10)
              $display("word %0d: expected left %0d right %0d, got left %0d right %0d",
                       n_words, exp_d.left, exp_d.right,
                       out_ch.left_drive, out_ch.right_drive);
          end
        end
      end
      if (took_in || took_out) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("no handshake for %0d cycles, %0d words outstanding",
                   idle_cycles, drive_expected.size());
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int ph, k;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.target = '0;
    in_ch.left_front = '0;
    in_ch.left_middle = '0;
    in_ch.left_back = '0;
    in_ch.right_front = '0;
    in_ch.right_middle = '0;
    in_ch.right_back = '0;
    in_ch.turning = 1'b0;
    in_ch.clear_state = 1'b0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset gains: plain moves, turns, stop, clear, field extremes, rounding
    ticks_pending.push_back(mk_tick(1000, 0, 0, 0, 0, 0, 0, 0, 0));
    ticks_pending.push_back(mk_tick(1000, 0, 0, 0, 100, 100, 100, 1, 0));
    ticks_pending.push_back(mk_tick(0, 55, 66, 77, 88, 99, 11, 1, 1));
    ticks_pending.push_back(mk_tick(0, PosMax, 3, 3, 3, 3, 3, 0, 0));
    ticks_pending.push_back(mk_tick(PosMax, PosMin, PosMin, PosMin, PosMin, PosMin, PosMin,
                                    0, 0));
    ticks_pending.push_back(mk_tick(PosMin, PosMax, PosMax, PosMax, PosMax, PosMax, PosMax,
                                    0, 0));
    ticks_pending.push_back(mk_tick(PosMax, PosMax, PosMax, PosMax, PosMin, PosMin, PosMin,
                                    1, 0));
    ticks_pending.push_back(mk_tick(1, PosMax, PosMax, PosMax, PosMax, PosMax, PosMax, 1, 1));
    ticks_pending.push_back(mk_tick(-1, PosMin, PosMin, PosMin, PosMin, PosMin, PosMin, 0, 0));
    // negative sums truncate toward zero
    ticks_pending.push_back(mk_tick(5, 0, 0, 0, -1, -1, -2, 1, 0));
    ticks_pending.push_back(mk_tick(3, -7, 0, 0, 0, 0, 0, 0, 0));
    ticks_pending.push_back(mk_tick(500, 100, 100, 100, 200, 200, 200, 0, 1));
    ticks_pending.push_back(mk_tick(24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA,
                                    24'sh555555, 24'shAAAAAA, 24'sh555555, 1, 0));
    ticks_pending.push_back(mk_tick(24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555,
                                    24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 0, 1));
    wait_drained();

    // unity p and i gain, tight integrator; move limit written too wide ends up zero
    apply_settings(24'd65536, 24'd65536, 24'd0, 24'hFFFF80, 24'd50, 24'd100);
    write_reg(RegSpareLo, 24'hFFFFFF);
    write_reg(RegSpareHi, 24'hFFFFFF);
    ticks_pending.push_back(mk_tick(10, 0, 0, 0, 0, 0, 0, 0, 0));
    ticks_pending.push_back(mk_tick(40, 0, 0, 0, 0, 0, 0, 1, 1));
    ticks_pending.push_back(mk_tick(40, 0, 0, 0, 0, 0, 0, 1, 0));
    ticks_pending.push_back(mk_tick(20, 0, 0, 0, 0, 0, 0, 1, 0));
    ticks_pending.push_back(mk_tick(-300, 0, 0, 0, 0, 0, 0, 1, 0));
    ticks_pending.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0, 1, 1));
    ticks_pending.push_back(mk_tick(3, 9, 9, 9, 3, 3, 4, 1, 0));
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_settings(GainMax, GainMax, GainMax, LimMax, LimMax, GainMax);
        1: apply_settings('0, '0, '0, '0, '0, '0);
        2: apply_settings(GainPRst, GainIRst, GainDRst, MoveLimRst, TurnLimRst, IntLimRst);
        default: apply_settings(pick_reg_value(GainMax, GainTyp),
                                pick_reg_value(GainMax, 24'd8192),
                                pick_reg_value(GainMax, GainTyp),
                                pick_reg_value(LimMax, LimMax),
                                pick_reg_value(LimMax, LimMax),
                                pick_reg_value(GainMax, 24'd20000));
      endcase
      // long output hold-off so the pipe fills and stalls its input
      if (ph == 2 || ph == 4) rx_hold_req = 1'b1;
      for (k = 0; k < PhaseTicks; k++) begin
        ticks_pending.push_back(random_tick());
        if (k % ChunkTicks == ChunkTicks - 1) begin
          while (ticks_pending.size() != 0) @(posedge clk_i);
          if ($urandom_range(0, 2) == 0) wait_drained();
        end
      end
      wait_drained();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (drive_expected.size() != 0) begin
      $display("%0d drive words never arrived", drive_expected.size());
      n_bad += drive_expected.size();
    end
    $display("%0d ticks (%0d turning, %0d stop, %0d clear) over %0d register settings",
             n_ticks_in, n_turn, n_stop, n_clear, n_settings + 1);
    $display("%0d drive words checked, %0d saturated, input held off %0d cycles",
             n_words, n_sat, n_backpressure);
    if (n_bad == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/dpid_pkg.sv
sv/dpid_if.sv
sv/dpid_integ.sv
sv/drive_pid_controller_unit.sv
verif/tb_drive_pid_controller_unit.sv
